### design/sst_pkg.sv
// ---------------------------------------------------------------------------
// sst_pkg: shared types, constants and functions
// Sizes of the sparse table, combine codes, channel word types and the
// combine function used by the update and query datapaths.
// ---------------------------------------------------------------------------
package sst_pkg;

  localparam int MAX_LENGTH  = 1024;
  localparam int LEVEL_COUNT = 11;
  localparam int VALUE_WIDTH = 32;

  localparam int POS_W     = $clog2(MAX_LENGTH);
  localparam int LEN_W     = POS_W + 1;
  localparam int LVL_W     = $clog2(LEVEL_COUNT);
  localparam int MEM_DEPTH = LEVEL_COUNT * MAX_LENGTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = LEN_W;

  localparam logic [MODE_W-1:0] MODE_MIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUM = 2'd2;

  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 1'd1;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_LENGTH);
  localparam logic [LVL_W-1:0] TOP_LEVEL = LVL_W'(LEVEL_COUNT - 1);

  typedef struct packed {
    logic                   opcode;
    logic [POS_W-1:0]       start_index;
    logic [LEN_W-1:0]       end_index;
    logic [VALUE_WIDTH-1:0] new_value;
  } in_word_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] aggregate;
    logic                   status;
  } out_word_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  length;
  } cfg_t;

  typedef struct packed {
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [VALUE_WIDTH-1:0] wdata;
    logic [ADDR_W-1:0]      raddr_a;
    logic [ADDR_W-1:0]      raddr_b;
  } mem_req_t;

  function automatic logic [VALUE_WIDTH-1:0] combine_values(
      input logic [MODE_W-1:0] mode,
      input logic [VALUE_WIDTH-1:0] a,
      input logic [VALUE_WIDTH-1:0] b);
    logic [VALUE_WIDTH-1:0] r;
    case (mode)
      MODE_MIN: r = (a < b) ? a : b;
      MODE_MAX: r = (a > b) ? a : b;
      default:  r = a + b;
    endcase
    return r;
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] combine_identity(
      input logic [MODE_W-1:0] mode);
    return (mode == MODE_MIN) ? {VALUE_WIDTH{1'b1}} : '0;
  endfunction

  function automatic logic [LVL_W-1:0] floor_log2(input logic [LEN_W-1:0] x);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int b = 1; b < LEN_W; b++) begin
      if (x[b]) r = LVL_W'(b);
    end
    return r;
  endfunction

endpackage

### design/sst_level_mem.sv
// ---------------------------------------------------------------------------
// sst_level_mem: sparse table storage
// All levels in one synchronous memory, one write port and two registered
// read ports, addressed by level and position.
// ---------------------------------------------------------------------------
module sst_level_mem (
  input  logic                            clk,
  input  sst_pkg::mem_req_t               req,
  output logic [sst_pkg::VALUE_WIDTH-1:0] rd_a,
  output logic [sst_pkg::VALUE_WIDTH-1:0] rd_b
);
  import sst_pkg::*;

  logic [VALUE_WIDTH-1:0] mem [0:MEM_DEPTH-1];
  logic [VALUE_WIDTH-1:0] rd_a_r;
  logic [VALUE_WIDTH-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    rd_a_r <= mem[req.raddr_a];
    rd_b_r <= mem[req.raddr_b];
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

### design/sst_engine.sv
// ---------------------------------------------------------------------------
// sst_engine: update and query sequencer
// Clears the table after reset, rebuilds covering runs level by level on an
// update and walks power-of-two blocks on a query.
// ---------------------------------------------------------------------------
module sst_engine (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sst_pkg::cfg_t                   cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sst_pkg::in_word_t               in_word,
  output logic                            res_valid,
  input  logic                            res_ready,
  output sst_pkg::out_word_t              res_word,
  output sst_pkg::mem_req_t               mem_req,
  input  logic [sst_pkg::VALUE_WIDTH-1:0] rd_a,
  input  logic [sst_pkg::VALUE_WIDTH-1:0] rd_b
);
  import sst_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_UPD   = 3'd2;
  localparam logic [2:0] ST_QRY   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]             state_r,   state_nxt;
  logic [ADDR_W-1:0]      clr_r,     clr_nxt;
  logic                   pend_r,    pend_nxt;
  logic [POS_W-1:0]       s_r,       s_nxt;
  logic [LEN_W-1:0]       e_r,       e_nxt;
  logic [LEN_W-1:0]       p_r,       p_nxt;
  logic [POS_W-1:0]       wpos_r,    wpos_nxt;
  logic [LVL_W-1:0]       lvl_r,     lvl_nxt;
  logic [LVL_W-1:0]       top_lvl_r, top_lvl_nxt;
  logic [VALUE_WIDTH-1:0] acc_r,     acc_nxt;
  out_word_t              res_r,     res_nxt;

  logic [LEN_W-1:0] k;
  logic [LEN_W-1:0] partner;
  logic [POS_W-1:0] last_pos;
  logic [LEN_W-1:0] span;
  logic [LVL_W-1:0] q_lvl;
  logic [LVL_W-1:0] n_lvl;

  function automatic logic [LEN_W-1:0] run_lo(input logic [POS_W-1:0] s,
                                              input logic [LVL_W-1:0] lvl);
    logic [LEN_W:0] blk;
    logic [LEN_W:0] sp1;
    blk = (LEN_W+1)'(1) << lvl;
    sp1 = (LEN_W+1)'(s) + (LEN_W+1)'(1);
    return (sp1 >= blk) ? LEN_W'(sp1 - blk) : '0;
  endfunction

  assign k        = LEN_W'(1) << (lvl_r - LVL_W'(1));
  assign partner  = p_r + k;
  assign last_pos = POS_W'(cfg.length - LEN_W'(1));
  assign span     = e_r - p_r;
  assign n_lvl    = (floor_log2(cfg.length) > TOP_LEVEL) ? TOP_LEVEL
                                                         : floor_log2(cfg.length);
  assign q_lvl    = (floor_log2(span) > TOP_LEVEL) ? TOP_LEVEL : floor_log2(span);

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    pend_nxt    = pend_r;
    s_nxt       = s_r;
    e_nxt       = e_r;
    p_nxt       = p_r;
    wpos_nxt    = wpos_r;
    lvl_nxt     = lvl_r;
    top_lvl_nxt = top_lvl_r;
    acc_nxt     = acc_r;
    res_nxt     = res_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    mem_req     = '0;

    case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
        clr_nxt       = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(MEM_DEPTH - 1)) state_nxt = ST_IDLE;
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        pend_nxt = 1'b0;
        if (in_valid) begin
          s_nxt = in_word.start_index;
          e_nxt = in_word.end_index;
          if (in_word.opcode == OP_UPDATE) begin
            if (LEN_W'(in_word.start_index) >= cfg.length) begin
              res_nxt   = '{aggregate: '0, status: STATUS_RANGE};
              state_nxt = ST_DONE;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.waddr = {LVL_W'(0), in_word.start_index};
              mem_req.wdata = in_word.new_value;
              top_lvl_nxt   = n_lvl;
              lvl_nxt       = LVL_W'(1);
              p_nxt         = run_lo(in_word.start_index, LVL_W'(1));
              if (n_lvl == LVL_W'(0)) begin
                res_nxt   = '{aggregate: '0, status: STATUS_OK};
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_UPD;
              end
            end
          end else begin
            if (LEN_W'(in_word.start_index) > cfg.length ||
                in_word.end_index > cfg.length) begin
              res_nxt   = '{aggregate: '0, status: STATUS_RANGE};
              state_nxt = ST_DONE;
            end else begin
              acc_nxt   = combine_identity(cfg.mode);
              p_nxt     = LEN_W'(in_word.start_index);
              state_nxt = ST_QRY;
            end
          end
        end
      end

      ST_UPD: begin
        mem_req.we    = pend_r;
        mem_req.waddr = {lvl_r, wpos_r};
        mem_req.wdata = combine_values(cfg.mode, rd_a, rd_b);
        if (p_r <= LEN_W'(s_r)) begin
          mem_req.raddr_a = {lvl_r - LVL_W'(1), p_r[POS_W-1:0]};
          mem_req.raddr_b = {lvl_r - LVL_W'(1),
                             (partner < cfg.length) ? partner[POS_W-1:0] : last_pos};
          pend_nxt = 1'b1;
          wpos_nxt = p_r[POS_W-1:0];
          p_nxt    = p_r + LEN_W'(1);
        end else begin
          pend_nxt = 1'b0;
          if (lvl_r == top_lvl_r) begin
            res_nxt   = '{aggregate: '0, status: STATUS_OK};
            state_nxt = ST_DONE;
          end else begin
            lvl_nxt = lvl_r + LVL_W'(1);
            p_nxt   = run_lo(s_r, lvl_r + LVL_W'(1));
          end
        end
      end

      ST_QRY: begin
        if (pend_r) acc_nxt = combine_values(cfg.mode, acc_r, rd_a);
        if (p_r < e_r) begin
          mem_req.raddr_a = {q_lvl, p_r[POS_W-1:0]};
          p_nxt    = p_r + (LEN_W'(1) << q_lvl);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            res_nxt   = '{aggregate: acc_r, status: STATUS_OK};
            state_nxt = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res_word = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r       <= s_nxt;
    e_r       <= e_nxt;
    p_r       <= p_nxt;
    wpos_r    <= wpos_nxt;
    lvl_r     <= lvl_nxt;
    top_lvl_r <= top_lvl_nxt;
    acc_r     <= acc_nxt;
    res_r     <= res_nxt;
  end

endmodule

### design/sparse_table_range_query.sv
// Update: writes level 0, then rebuilds the covering runs of levels 1..floor(log2(n)),
//   one table entry per cycle on the single write port.
// Query: walks at most 10 power-of-two blocks, none for an empty range;
//   an out-of-range word returns a range error status instead.
// One word at a time; a finished result waits in the output register meanwhile.
// Reset: synchronous, active low; a clearing pass zeroes every table entry
//   before the first word is taken.
// ---------------------------------------------------------------------------
// sparse_table_range_query: sparse table range aggregate block
// Configuration registers, effective mode and length, output register and
// the sequencer with its level memory.
// ---------------------------------------------------------------------------
module sparse_table_range_query (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sst_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sst_pkg::in_word_t             in_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sst_pkg::out_word_t            out_word
);
  import sst_pkg::*;

  logic [MODE_W-1:0]      mode_r, mode_nxt;
  logic [LEN_W-1:0]       len_r,  len_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_word_r;
  cfg_t                   cfg;
  logic                   res_valid;
  logic                   res_ready;
  out_word_t              res_word;
  mem_req_t               mem_req;
  logic [VALUE_WIDTH-1:0] rd_a;
  logic [VALUE_WIDTH-1:0] rd_b;

  always_comb begin
    mode_nxt = mode_r;
    len_nxt  = len_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:   mode_nxt = cfg_wdata[MODE_W-1:0];
        CFG_LENGTH: len_nxt  = cfg_wdata[LEN_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    cfg.mode = (mode_r == MODE_MIN || mode_r == MODE_MAX) ? mode_r : MODE_SUM;
    if (len_r == '0) cfg.length = LEN_W'(1);
    else if (len_r > LEN_W'(MAX_LENGTH)) cfg.length = LEN_W'(MAX_LENGTH);
    else cfg.length = len_r;
  end

  assign res_ready     = !out_valid_r || out_ready;
  assign out_valid_nxt = res_valid || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_MIN;
      len_r       <= LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_word_r <= res_word;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  sst_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word),
    .mem_req   (mem_req),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  sst_level_mem u_mem (
    .clk  (clk),
    .req  (mem_req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

endmodule
